// ===== rtl/core/qldt_pkg.sv =====
// ----------------------------------------------------------------------------
// qldt_pkg
// Shared types, codes and sizes for the quorum lease deadline tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qldt_pkg;

    localparam int PEERS   = 8;
    localparam int PEER_W  = $clog2(PEERS);
    localparam int CNT_W   = $clog2(PEERS + 1);
    localparam int TIME_W  = 64;
    localparam int SPAN_W  = 32;
    localparam int MASK_W  = 8;
    localparam int QUORUM_W = 4;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUORUM    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SHAKY     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUORUM_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SPAN  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/quorum_lease_deadline_tracker.sv =====
// ----------------------------------------------------------------------------
// quorum_lease_deadline_tracker
// Per-peer last-contact store with quorum lease deadline selection.
// ----------------------------------------------------------------------------
// A heartbeat request never stalls the input, so heartbeats may follow one
// another while no query holds o_stall. A deadline query runs a rank scan
// with one shared rank unit: each of eight scan steps compares one candidate
// slot against every slot and keeps it when its rank matches the quorum rank,
// then the done state adds the lease span with saturation and loads the
// result into the output register. A query holds o_stall through the scan and
// the done state; the single-node and no-target cases skip the scan and go
// straight to the done state. Either case holds o_stall longer while an
// earlier result is still stalled at the output. The output register lets
// the next request in while a result still waits.
`timescale 1ns / 1ps
`default_nettype none

module quorum_lease_deadline_tracker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [qldt_pkg::CMD_W-1:0]            i_cmd,
    input  wire logic [2:0]                            i_peer,
    input  wire logic [qldt_pkg::TIME_W-1:0]           i_contact_time,
    input  wire logic [qldt_pkg::TIME_W-1:0]           i_now_time,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [qldt_pkg::TIME_W-1:0]                o_deadline,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [qldt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [qldt_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    qldt_pkg::t_state r_state, n_state;

    logic [qldt_pkg::TIME_W-1:0]   r_last [qldt_pkg::PEERS];
    logic [qldt_pkg::MASK_W-1:0]   r_mask;
    logic [qldt_pkg::QUORUM_W-1:0] r_quorum;
    logic [qldt_pkg::SPAN_W-1:0]   r_span;
    logic [qldt_pkg::PEER_W-1:0]   r_idx;
    logic [qldt_pkg::PEER_W-1:0]   r_rank, n_rank;
    logic [qldt_pkg::TIME_W-1:0]   r_sel;
    logic                          r_out_valid;
    logic [qldt_pkg::TIME_W-1:0]   r_deadline;

    logic                          s_accept;
    logic                          s_query;
    logic                          s_direct;
    logic                          s_load_out;
    logic                          s_scan_last;
    logic                          s_hb_write;
    logic [qldt_pkg::CNT_W-1:0]    s_tcount;
    logic [qldt_pkg::CNT_W:0]      s_n;
    logic [qldt_pkg::CNT_W:0]      s_tp1;
    logic [qldt_pkg::CNT_W:0]      s_rank_raw;
    logic [qldt_pkg::TIME_W-1:0]   s_cand;
    logic [qldt_pkg::CNT_W-1:0]    s_lt;
    logic [qldt_pkg::CNT_W-1:0]    s_le;
    logic                          s_hit;
    logic [qldt_pkg::TIME_W:0]     s_sum;

    // target count and quorum rank
    always_comb begin
        s_tcount = '0;
        for (int i = 0; i < qldt_pkg::PEERS; i++) begin
            s_tcount = s_tcount + qldt_pkg::CNT_W'(r_mask[i]);
        end
        s_n   = {1'b0, r_quorum} + ((i_cmd == qldt_pkg::CMD_SHAKY) ? 5'd1 : 5'd0);
        s_tp1 = {1'b0, s_tcount} + 5'd1;
        if (s_n > s_tp1) begin
            s_rank_raw = '0;
        end else begin
            s_rank_raw = s_tp1 - s_n;
        end
        if (s_rank_raw > ({1'b0, s_tcount} - 5'd1)) begin
            s_rank_raw = {1'b0, s_tcount} - 5'd1;
        end
        n_rank = s_rank_raw[qldt_pkg::PEER_W-1:0];
    end

    // shared rank unit: one candidate against all slots
    always_comb begin
        s_cand = r_last[r_idx];
        s_lt   = '0;
        s_le   = '0;
        for (int j = 0; j < qldt_pkg::PEERS; j++) begin
            s_lt = s_lt + qldt_pkg::CNT_W'(r_mask[j] && (r_last[j] < s_cand));
            s_le = s_le + qldt_pkg::CNT_W'(r_mask[j] && (r_last[j] <= s_cand));
        end
        s_hit = r_mask[r_idx] && (s_lt <= {1'b0, r_rank}) && ({1'b0, r_rank} < s_le);
    end

    assign s_sum = {1'b0, r_sel} + {{(qldt_pkg::TIME_W - qldt_pkg::SPAN_W + 1){1'b0}}, r_span};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qldt_pkg::ST_IDLE: begin
                if (s_accept && s_query) begin
                    n_state = s_direct ? qldt_pkg::ST_DONE : qldt_pkg::ST_SCAN;
                end
            end
            qldt_pkg::ST_SCAN: begin
                if (s_scan_last) begin
                    n_state = qldt_pkg::ST_DONE;
                end
            end
            qldt_pkg::ST_DONE: begin
                if (s_load_out) begin
                    n_state = qldt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qldt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and strobes
    always_comb begin
        o_stall     = (r_state != qldt_pkg::ST_IDLE);
        s_accept    = i_valid && !o_stall;
        s_query     = (i_cmd == qldt_pkg::CMD_QUORUM) || (i_cmd == qldt_pkg::CMD_SHAKY);
        s_direct    = (r_quorum == 4'd1) || (s_tcount == '0);
        s_scan_last = (r_state == qldt_pkg::ST_SCAN)
                      && (r_idx == qldt_pkg::PEER_W'(qldt_pkg::PEERS - 1));
        s_load_out  = (r_state == qldt_pkg::ST_DONE) && (!r_out_valid || !i_stall);
        s_hb_write  = s_accept && (i_cmd == qldt_pkg::CMD_HEARTBEAT)
                      && (r_last[i_peer] < i_contact_time);
        o_valid     = r_out_valid;
        o_deadline  = r_deadline;
        o_cfg_ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qldt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
            r_quorum    <= 4'd1;
            r_span      <= '0;
            r_idx       <= '0;
            for (int i = 0; i < qldt_pkg::PEERS; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    qldt_pkg::CFG_TARGET_MASK: r_mask   <= i_cfg_data[qldt_pkg::MASK_W-1:0];
                    qldt_pkg::CFG_QUORUM_SIZE: r_quorum <= i_cfg_data[qldt_pkg::QUORUM_W-1:0];
                    qldt_pkg::CFG_LEASE_SPAN:  r_span   <= i_cfg_data[qldt_pkg::SPAN_W-1:0];
                    default: ;
                endcase
            end

            if (s_hb_write) begin
                r_last[i_peer] <= i_contact_time;
            end

            if (s_accept && s_query) begin
                r_idx <= '0;
            end else if (r_state == qldt_pkg::ST_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end

            if (s_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && s_query) begin
            r_rank <= n_rank;
            r_sel  <= i_now_time;
        end else if ((r_state == qldt_pkg::ST_SCAN) && s_hit) begin
            r_sel <= s_cand;
        end
        if (s_load_out) begin
            r_deadline <= s_sum[qldt_pkg::TIME_W] ? {qldt_pkg::TIME_W{1'b1}}
                                                  : s_sum[qldt_pkg::TIME_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/qldt_checker.sv =====
// ----------------------------------------------------------------------------
// qldt_checker
// Port-level checks for the quorum lease deadline tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qldt_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic [qldt_pkg::CMD_W-1:0]      i_cmd,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [qldt_pkg::TIME_W-1:0]     o_deadline
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_deadline)))
        else $error("result changed while stalled");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall
         && (i_cmd == qldt_pkg::CMD_QUORUM || i_cmd == qldt_pkg::CMD_SHAKY))
        |=> o_stall)
        else $error("query request did not hold the input");

    a_hb_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall
         && !(i_cmd == qldt_pkg::CMD_QUORUM || i_cmd == qldt_pkg::CMD_SHAKY))
        |=> !o_stall)
        else $error("heartbeat request stalled the input");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && $past(i_rst_n)) |-> !o_stall)
        else $error("result shown while query still busy");

endmodule

bind quorum_lease_deadline_tracker qldt_checker u_qldt_checker (.*);

`default_nettype wire
